>>> rtl/core/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg: shared types for the single-value totient unit
// Status bundle reported by the bit-serial divider to its controller.
// ----------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } svt_div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/single_value_totient_unit.sv
// ----------------------------------------------------------------------------
// single_value_totient_unit: Euler totient by trial division
// Strips each trial divisor from the value with a bit-serial divider and
// scales the running answer, then applies any leftover prime factor.
//
// Channel   Ports                      Transfer
// input     start, busy, value_in      start high while busy low
// result    done, totient_out          done high for one cycle
//
// Every divide runs through the shared bit-serial divider; a transaction
// costs one divide per trial divisor plus one per factor stripped and one
// per distinct prime.
// One transaction is in flight; busy stays high until the done cycle.
// Reset clears control state only. The receiver cannot stall: done is a
// strobe and totient_out is valid only in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module single_value_totient_unit
    import svt_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] value_in,
    output logic                       done,
    output logic [VALUE_BITS-1:0]      totient_out
);

    localparam int W  = VALUE_BITS;
    localparam int DW = (W + 1) / 2 + 1;
    localparam logic [DW-1:0] FIRST_DIV = DW'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_STRIP,
        ST_SCALE,
        ST_LAST
    } state_t;

    state_t        state_reg;
    logic [W-1:0]  rest_reg;
    logic [W-1:0]  acc_reg;
    logic [DW-1:0] dvs_reg;
    logic          go_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W-1:0]  tot_reg;

    logic [W-1:0]  quo;
    logic [W-1:0]  rem;
    svt_div_stat_t div_stat;

    logic [W-1:0]  dvs_wide;
    logic [DW-1:0] dvs_next;
    logic [W-1:0]  dvs_next_wide;
    logic          rem_zero;

    assign dvs_wide      = {{(W-DW){1'b0}}, dvs_reg};
    assign dvs_next      = dvs_reg + 1'b1;
    assign dvs_next_wide = {{(W-DW){1'b0}}, dvs_next};
    assign rem_zero      = (rem == '0);

    svt_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go_reg),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .quotient  (quo),
        .remainder (rem),
        .stat      (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        rest_reg  <= value_in;
                        acc_reg   <= value_in;
                        dvs_reg   <= FIRST_DIV;
                        a_reg     <= value_in;
                        b_reg     <= {{(W-DW){1'b0}}, FIRST_DIV};
                        go_reg    <= 1'b1;
                        busy_reg  <= 1'b1;
                        state_reg <= ST_TRIAL;
                    end
                end
                ST_TRIAL:
                begin
                    if (div_stat.done)
                    begin
                        if (dvs_wide > quo)
                        begin
                            if (rest_reg > W'(1))
                            begin
                                a_reg     <= acc_reg;
                                b_reg     <= rest_reg;
                                go_reg    <= 1'b1;
                                state_reg <= ST_LAST;
                            end
                            else
                            begin
                                tot_reg   <= acc_reg;
                                done_reg  <= 1'b1;
                                busy_reg  <= 1'b0;
                                state_reg <= ST_IDLE;
                            end
                        end
                        else if (rem_zero)
                        begin
                            rest_reg  <= quo;
                            a_reg     <= quo;
                            b_reg     <= dvs_wide;
                            go_reg    <= 1'b1;
                            state_reg <= ST_STRIP;
                        end
                        else
                        begin
                            dvs_reg <= dvs_next;
                            a_reg   <= rest_reg;
                            b_reg   <= dvs_next_wide;
                            go_reg  <= 1'b1;
                        end
                    end
                end
                ST_STRIP:
                begin
                    if (div_stat.done)
                    begin
                        if (rem_zero)
                        begin
                            rest_reg <= quo;
                            a_reg    <= quo;
                            b_reg    <= dvs_wide;
                        end
                        else
                        begin
                            a_reg     <= acc_reg;
                            b_reg     <= dvs_wide;
                            state_reg <= ST_SCALE;
                        end
                        go_reg <= 1'b1;
                    end
                end
                ST_SCALE:
                begin
                    if (div_stat.done)
                    begin
                        acc_reg   <= acc_reg - quo;
                        dvs_reg   <= dvs_next;
                        a_reg     <= rest_reg;
                        b_reg     <= dvs_next_wide;
                        go_reg    <= 1'b1;
                        state_reg <= ST_TRIAL;
                    end
                end
                ST_LAST:
                begin
                    if (div_stat.done)
                    begin
                        tot_reg   <= acc_reg - quo;
                        done_reg  <= 1'b1;
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign totient_out = tot_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is still open");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && go_reg))
        else $error("accepted transaction did not launch a divide");

    a_go_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |-> !div_stat.busy)
        else $error("divide launched while divider still running");

    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg != ST_IDLE))
        else $error("divider finished with no transaction open");

endmodule

`default_nettype wire

>>> rtl/core/svt_div.sv
// ----------------------------------------------------------------------------
// svt_div: bit-serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_div
    import svt_pkg::*;
#(
    parameter int W = 31
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder,
    output svt_div_stat_t     stat
);

    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  quo_next;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = ~diff[W];
    assign rem_next = fits ? diff[W-1:0] : trial[W-1:0];
    assign quo_next = {quo_reg[W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= LAST_BIT;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
